[sv/sbglg_pkg.sv]
// Shared types and constants for the scrolling bar graph line generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sbglg_pkg;

	// Field widths fixed by the transaction formats
	localparam int SAMPLE_BITS = 16;
	localparam int COORD_BITS  = 10;
	localparam int DIV_BITS    = 16;
	// Dividend is the sample magnitude without its sign bit
	localparam int DVD_BITS    = SAMPLE_BITS - 1;
	localparam int STEP_BITS   = $clog2(DVD_BITS + 1);

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_START_X      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_Y      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRAPH_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIVIDER      = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_WIDTH = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_INCREMENTAL  = 3'd5;

	localparam logic [COORD_BITS-1:0] GRAPH_HEIGHT_RST = 10'd64;
	localparam logic [DIV_BITS-1:0]   DIVIDER_RST      = 16'd1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          frame_start;
		logic signed [SAMPLE_BITS-1:0] evicted_sample;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] line_x;
		logic [COORD_BITS:0]   line_y;
		logic [COORD_BITS-1:0] line_length;
		logic                  erase;
		logic                  last_of_item;
	} out_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] graph_height;
		logic [DIV_BITS-1:0]   divider;
		logic                  double_width;
		logic                  incremental;
	} cfg_t;

	// Classified item as held in the queue between front and back
	typedef struct packed {
		logic [DVD_BITS-1:0] cur_dvd;
		logic                frame_start;
		logic                need_ref;
		logic [DVD_BITS-1:0] ref_dvd;
	} job_t;

	typedef struct packed {
		logic                go;
		logic [DVD_BITS-1:0] dividend;
		logic [DIV_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DVD_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

[sv/sbglg_front.sv]
// Front end: accepts sample transactions, classifies them and queues them.
// Depends on sbglg_pkg.
`default_nettype none

module sbglg_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  sbglg_pkg::in_item_t     in_item,
	input  wire                     incremental,
	output logic                    job_valid,
	input  wire                     job_pop,
	output sbglg_pkg::job_t         job
);
	import sbglg_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	job_t                q_mem [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	job_t                new_job;
	logic                push;
	logic                pop;

	// Negative samples give a zero bar: feed a zero dividend
	always_comb begin
		new_job.cur_dvd     = in_item.sample[SAMPLE_BITS-1] ? '0
			: in_item.sample[DVD_BITS-1:0];
		new_job.frame_start = in_item.frame_start;
		new_job.need_ref    = in_item.frame_start & incremental;
		new_job.ref_dvd     = in_item.evicted_sample[SAMPLE_BITS-1] ? '0
			: in_item.evicted_sample[DVD_BITS-1:0];
	end

	assign in_stall  = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign push      = in_valid & ~in_stall;
	assign job_valid = (count_q != '0);
	assign pop       = job_pop & job_valid;
	assign job       = q_mem[rd_ptr_q];

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_job;
		end
	end

endmodule

`default_nettype wire

[sv/sbglg_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on sbglg_pkg.
`default_nettype none

module sbglg_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sbglg_pkg::div_req_t  req,
	output sbglg_pkg::div_rsp_t  rsp
);
	import sbglg_pkg::*;

	logic [STEP_BITS-1:0] step_q;
	logic                 done_q;
	logic [DVD_BITS-1:0]  dvd_q;
	logic [DIV_BITS-1:0]  rem_q;
	logic [DIV_BITS:0]    trial;
	logic [DIV_BITS:0]    diff;
	logic                 qbit;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[DVD_BITS-1]};
	assign diff  = trial - {1'b0, req.divisor};
	assign qbit  = ~diff[DIV_BITS];

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

	// Step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ~req.go & (step_q == STEP_BITS'(1));
			if (req.go) begin
				step_q <= STEP_BITS'(DVD_BITS);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// Dividend register collects quotient bits from the bottom
	always_ff @(posedge clk) begin
		if (req.go) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[DVD_BITS-2:0], qbit};
			rem_q <= qbit ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

[sv/sbglg_back.sv]
// Back end: sequences bar height divisions and emits line commands.
// Depends on sbglg_pkg; drives an sbglg_div instance through req/rsp.
`default_nettype none

module sbglg_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sbglg_pkg::cfg_t      cfg,
	input  wire                  job_valid,
	output logic                 job_pop,
	input  sbglg_pkg::job_t      job,
	output sbglg_pkg::div_req_t  div_req,
	input  sbglg_pkg::div_rsp_t  div_rsp,
	output logic                 out_valid,
	input  wire                  out_stall,
	output sbglg_pkg::out_item_t out_item
);
	import sbglg_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CUR,
		S_REF,
		S_EMIT
	} state_t;

	state_t                state_q;
	job_t                  job_q;
	logic [COORD_BITS:0]   col_q;
	logic                  col_idx_q;
	logic [COORD_BITS-1:0] prev_q;
	logic [COORD_BITS-1:0] cur_q;
	logic [COORD_BITS-1:0] ref_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [COORD_BITS-1:0] height;
	logic [COORD_BITS:0]   base;
	logic                  has_line;
	logic                  advance;
	logic                  last_col;
	out_item_t             line;

	// Clamp quotient to the graph height
	assign height = (div_rsp.quotient > DVD_BITS'(cfg.graph_height)) ? cfg.graph_height
		: div_rsp.quotient[COORD_BITS-1:0];

	// Divider requests: current sample on dispatch, then the evicted sample when a reference is needed
	always_comb begin
		div_req.go       = 1'b0;
		div_req.dividend = job.cur_dvd;
		div_req.divisor  = (cfg.divider == '0) ? DIV_BITS'(1) : cfg.divider;
		if (state_q == S_IDLE) begin
			div_req.go = job_valid;
		end else if (state_q == S_CUR) begin
			div_req.go       = div_rsp.done & job_q.need_ref;
			div_req.dividend = job_q.ref_dvd;
		end
	end

	assign job_pop = (state_q == S_IDLE) & job_valid;

	// Line command for the current column
	always_comb begin
		base             = {1'b0, cfg.start_y} + {1'b0, cfg.graph_height};
		last_col         = col_idx_q | ~cfg.double_width;
		has_line         = ~cfg.incremental | (ref_q != cur_q);
		line.line_x      = col_q[COORD_BITS-1:0];
		line.last_of_item = last_col;
		if (!cfg.incremental) begin
			line.line_y      = base - {1'b0, cur_q};
			line.line_length = cur_q;
			line.erase       = 1'b0;
		end else if (ref_q > cur_q) begin
			line.line_y      = base - {1'b0, ref_q};
			line.line_length = ref_q - cur_q;
			line.erase       = 1'b1;
		end else begin
			line.line_y      = base - {1'b0, cur_q};
			line.line_length = cur_q - ref_q;
			line.erase       = 1'b0;
		end
	end

	assign advance = (state_q == S_EMIT) & (~has_line | ~out_valid_q | ~out_stall);

	// Sequencer, column state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= '0;
			col_q       <= '0;
			col_idx_q   <= 1'b0;
			prev_q      <= '0;
			cur_q       <= '0;
			ref_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// output register holds its line until taken, refills on emit
			out_valid_q <= (out_valid_q & out_stall) | (advance & has_line);
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						state_q <= S_CUR;
						if (job.frame_start) begin
							col_q <= {1'b0, cfg.start_x};
						end
					end
				end
				S_CUR: begin
					if (div_rsp.done) begin
						cur_q <= height;
						if (job_q.need_ref) begin
							state_q <= S_REF;
						end else begin
							ref_q   <= prev_q;
							state_q <= S_EMIT;
						end
					end
				end
				S_REF: begin
					if (div_rsp.done) begin
						ref_q   <= height;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (advance) begin
						if (has_line) begin
							out_q <= line;
						end
						col_q <= col_q + 1'b1;
						if (last_col) begin
							col_idx_q <= 1'b0;
							prev_q    <= cur_q;
							state_q   <= S_IDLE;
						end else begin
							col_idx_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

[sv/scrolling_bar_graph_line_generator.sv]
// Scrolling bar graph line generator, top level.
// A frame start in incremental mode also divides the evicted sample before the
// first line command of that sample is registered. The back end handles one sample
// at a time, using the serial divider that takes one quotient bit per cycle; the
// input queue keeps accepting samples meanwhile until it is full.
// Reset clears the queue, sequencer, column and previous height, and sets the configuration to its reset values.
`default_nettype none

module scrolling_bar_graph_line_generator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       in_valid,
	output logic                                      in_stall,
	input  sbglg_pkg::in_item_t                       in_item,
	output logic                                      out_valid,
	input  wire                                       out_stall,
	output sbglg_pkg::out_item_t                      out_item,
	input  wire                                       cfg_valid,
	output logic                                      cfg_ready,
	input  wire [sbglg_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  wire [sbglg_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
	import sbglg_pkg::*;

	cfg_t     cfg_q;
	logic     job_valid;
	logic     job_pop;
	job_t     job;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x      <= '0;
			cfg_q.start_y      <= '0;
			cfg_q.graph_height <= GRAPH_HEIGHT_RST;
			cfg_q.divider      <= DIVIDER_RST;
			cfg_q.double_width <= 1'b0;
			cfg_q.incremental  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_X:      cfg_q.start_x      <= cfg_data[COORD_BITS-1:0];
				REG_START_Y:      cfg_q.start_y      <= cfg_data[COORD_BITS-1:0];
				REG_GRAPH_HEIGHT: cfg_q.graph_height <= cfg_data[COORD_BITS-1:0];
				REG_DIVIDER:      cfg_q.divider      <= cfg_data[DIV_BITS-1:0];
				REG_DOUBLE_WIDTH: cfg_q.double_width <= cfg_data[0];
				REG_INCREMENTAL:  cfg_q.incremental  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	sbglg_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.incremental(cfg_q.incremental),
		.job_valid  (job_valid),
		.job_pop    (job_pop),
		.job        (job)
	);

	sbglg_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	sbglg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job      (job),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	// Incremental lines always cover a nonzero height difference
	a_incr_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfg_q.incremental) |-> (out_item.line_length != '0))
		else $error("zero-length line in incremental mode");

	// Erase lines only come from incremental mode
	a_erase_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.erase) |-> cfg_q.incremental)
		else $error("erase line in full mode");

	// Full mode bars reach exactly down to the baseline
	a_full_base: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg_q.incremental) |->
		((12'(out_item.line_y) + 12'(out_item.line_length)) ==
		 (12'(cfg_q.start_y) + 12'(cfg_q.graph_height))))
		else $error("full mode bar does not end at baseline");

endmodule

`default_nettype wire
